// ===== hdl/ipv6_transport_checksum_check_fill_top_macros.svh =====
// Assertion macros shared by the IPv6 transport checksum RTL.
`ifndef IPV6_TRANSPORT_CHECKSUM_CHECK_FILL_TOP_MACROS_SVH
`define IPV6_TRANSPORT_CHECKSUM_CHECK_FILL_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IP6CS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IP6CS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ip6csum_pkg.sv =====
// Types and constants for the IPv6 transport checksum check and fill block.
package ip6csum_pkg;

    // Next-header codes that the block handles.
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    // Fixed IPv6 header length in bytes.
    localparam int unsigned IP6_HDR_BYTES = 40;

    // Byte offsets inside the packet.
    localparam int unsigned OFS_NEXT_HDR   = 6;
    localparam int unsigned OFS_ADDR_START = 8;
    localparam int unsigned OFS_ICMP_CSUM  = 42;
    localparam int unsigned OFS_UDP_LEN    = 44;
    localparam int unsigned OFS_UDP_CSUM   = 46;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_TRUNCATED   = 2'd2
    } status_t;

endpackage

// ===== hdl/ipv6_transport_checksum_check_fill_top.sv =====
// IPv6 UDP/ICMPv6 checksum computation, check and fill value, one byte per beat.
//
//  channel | dir | tdata (lowest bit first)                | tlast
//  --------+-----+-----------------------------------------+-----------------
//  s_      | in  | data_byte[7:0]                          | last_byte
//  m_      | out | fill_value[15:0], checksum_ok, status   | none
//
// One byte is accepted every cycle unless a final byte waits for the finish
// stage; each pair of bytes adds one 16-bit word to the running sum in a single
// pass. After a final byte is accepted, the sum/capture stage loads the finish
// register, then the fold-and-complement stage loads the output register.
// Reset (aresetn low, synchronous) empties the pipeline and clears the state.
// A stalled result stops only the stages behind it that hold a final byte;
// ordinary bytes keep flowing while a result waits on m_tready.
`include "ipv6_transport_checksum_check_fill_top_macros.svh"

module ipv6_transport_checksum_check_fill_top
    import ip6csum_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // fill_value[15:0], checksum_ok[16], status[18:17]
);

    localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);

    // Input register.
    logic       in_v_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    // Per-packet state.
    logic [POS_W-1:0] pos_reg;
    logic [31:0]      sum_reg;
    logic [7:0]       held_reg;
    logic [7:0]       nh_reg;
    logic [15:0]      stored_reg;
    logic [15:0]      tlen_reg;

    // Finish stage register.
    logic        fin_v_reg;
    logic [31:0] fin_sum_reg;
    logic [15:0] fin_plen_reg;
    logic [7:0]  fin_nh_reg;
    status_t     fin_status_reg;
    logic [15:0] fin_stored_reg;

    // Output register.
    logic        out_v_reg;
    logic [23:0] out_data_reg;

    // Handshake between stages.
    logic out_ready;
    logic fin_ready;
    logic in_adv;
    logic in_ready;

    assign out_ready = !out_v_reg || m_tready;
    assign fin_ready = !fin_v_reg || out_ready;
    assign in_adv    = in_v_reg && (!in_last_reg || fin_ready);
    assign in_ready  = !in_v_reg || in_adv;
    assign s_tready  = in_ready;
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = out_data_reg;

    // Sum and capture logic for the byte in the input register.
    logic             pos_ovf;
    logic [7:0]       nh_next;
    logic [15:0]      tlen_next;
    logic [15:0]      stored_next;
    logic [7:0]       held_next;
    logic [31:0]      sum_next;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       byte_val;
    logic [15:0]      word_val;
    logic             counts;
    logic             is_udp;
    logic             is_icmp;
    logic [16:0]      total;
    logic [16:0]      udp_end;
    logic [16:0]      udp_end_fin;
    status_t          status_next;
    logic [15:0]      plen_next;

    always_comb begin
        pos_ovf     = pos_reg >= POS_W'(MAX_PACKET_BYTES);
        nh_next     = nh_reg;
        tlen_next   = tlen_reg;
        stored_next = stored_reg;
        held_next   = held_reg;
        sum_next    = sum_reg;
        pos_next    = pos_reg;
        byte_val    = in_data_reg;
        word_val    = 16'h0000;
        counts      = 1'b0;
        udp_end     = 17'(IP6_HDR_BYTES) + 17'(tlen_reg);

        if (!pos_ovf) begin
            // Capture header fields; checksum bytes count as zero.
            if (pos_reg == POS_W'(OFS_NEXT_HDR)) begin
                nh_next = in_data_reg;
            end
            if (nh_next == PROTO_UDP) begin
                if (pos_reg == POS_W'(OFS_UDP_LEN) || pos_reg == POS_W'(OFS_UDP_LEN + 1)) begin
                    tlen_next = {tlen_reg[7:0], in_data_reg};
                end
                if (pos_reg == POS_W'(OFS_UDP_CSUM) ||
                    pos_reg == POS_W'(OFS_UDP_CSUM + 1)) begin
                    stored_next = {stored_reg[7:0], in_data_reg};
                    byte_val    = 8'h00;
                end
            end else if (nh_next == PROTO_ICMPV6) begin
                if (pos_reg == POS_W'(OFS_ICMP_CSUM) ||
                    pos_reg == POS_W'(OFS_ICMP_CSUM + 1)) begin
                    stored_next = {stored_reg[7:0], in_data_reg};
                    byte_val    = 8'h00;
                end
            end

            // Decide whether the byte belongs to the checksummed span.
            if (pos_reg < POS_W'(OFS_ADDR_START)) begin
                counts = 1'b0;
            end else if (pos_reg < POS_W'(IP6_HDR_BYTES)) begin
                counts = 1'b1;
            end else if (nh_next == PROTO_ICMPV6) begin
                counts = 1'b1;
            end else if (nh_next == PROTO_UDP) begin
                if (pos_reg < POS_W'(OFS_UDP_CSUM)) begin
                    counts = 1'b1;
                end else begin
                    counts = 17'(pos_reg) < udp_end;
                end
            end
            if (!counts) begin
                byte_val = 8'h00;
            end

            // Pair bytes into big-endian words; an odd final byte is padded.
            if (!pos_reg[0]) begin
                held_next = byte_val;
                word_val  = in_last_reg ? {byte_val, 8'h00} : 16'h0000;
            end else begin
                word_val = {held_reg, byte_val};
            end
            sum_next = sum_reg + 32'(word_val);
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // Result status and upper-layer length for a final byte.
    always_comb begin
        is_udp      = nh_next == PROTO_UDP;
        is_icmp     = nh_next == PROTO_ICMPV6;
        total       = 17'(pos_reg) + 17'd1;
        udp_end_fin = 17'(IP6_HDR_BYTES) + 17'(tlen_next);
        status_next = ST_OK;
        plen_next   = 16'h0000;
        if (pos_reg < POS_W'(OFS_NEXT_HDR)) begin
            status_next = ST_TRUNCATED;
        end else if (!is_udp && !is_icmp) begin
            status_next = ST_UNSUPPORTED;
        end else if (pos_ovf) begin
            status_next = ST_TRUNCATED;
        end else if (is_udp) begin
            if (total < 17'(OFS_UDP_CSUM + 2) || tlen_next < 16'd8 || total < udp_end_fin) begin
                status_next = ST_TRUNCATED;
            end
            plen_next = tlen_next;
        end else begin
            if (total < 17'(OFS_UDP_LEN)) begin
                status_next = ST_TRUNCATED;
            end else begin
                plen_next = 16'(total - 17'(IP6_HDR_BYTES));
            end
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tvalid && in_ready) begin
            in_v_reg <= 1'b1;
        end else if (in_adv) begin
            in_v_reg <= 1'b0;
        end
        if (s_tvalid && in_ready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Per-packet state; cleared after every final byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            held_reg   <= '0;
            nh_reg     <= '0;
            stored_reg <= '0;
            tlen_reg   <= '0;
        end else if (in_adv) begin
            if (in_last_reg) begin
                pos_reg    <= '0;
                sum_reg    <= '0;
                held_reg   <= '0;
                nh_reg     <= '0;
                stored_reg <= '0;
                tlen_reg   <= '0;
            end else begin
                pos_reg    <= pos_next;
                sum_reg    <= sum_next;
                held_reg   <= held_next;
                nh_reg     <= nh_next;
                stored_reg <= stored_next;
                tlen_reg   <= tlen_next;
            end
        end
    end

    // Finish stage register: holds one completed packet's sum.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_v_reg <= 1'b0;
        end else if (in_adv && in_last_reg) begin
            fin_v_reg <= 1'b1;
        end else if (fin_v_reg && out_ready) begin
            fin_v_reg <= 1'b0;
        end
        if (in_adv && in_last_reg) begin
            fin_sum_reg    <= sum_next;
            fin_plen_reg   <= plen_next;
            fin_nh_reg     <= nh_next;
            fin_status_reg <= status_next;
            fin_stored_reg <= stored_next;
        end
    end

    // Pseudo-header add, end-around carry fold and complement.
    logic [31:0] fold_in;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] csum;
    logic [15:0] fill_calc;
    logic        ok_calc;
    logic [15:0] fill_out;
    logic        ok_out;

    always_comb begin
        fold_in = fin_sum_reg + 32'(fin_plen_reg) + 32'(fin_nh_reg);
        fold1   = 17'(fold_in[15:0]) + 17'(fold_in[31:16]);
        fold2   = fold1[15:0] + 16'(fold1[16]);
        csum    = ~fold2;
        if (fin_nh_reg == PROTO_UDP) begin
            fill_calc = (csum == 16'h0000) ? 16'hFFFF : csum;
            ok_calc   = fill_calc == fin_stored_reg;
        end else begin
            fill_calc = csum;
            ok_calc   = (fin_stored_reg == csum) ||
                        (fin_stored_reg == 16'hFFFF && csum == 16'h0000);
        end
        if (fin_status_reg == ST_OK) begin
            fill_out = fill_calc;
            ok_out   = ok_calc;
        end else begin
            fill_out = 16'h0000;
            ok_out   = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (fin_v_reg && out_ready) begin
            out_v_reg <= 1'b1;
        end else if (m_tready) begin
            out_v_reg <= 1'b0;
        end
        if (fin_v_reg && out_ready) begin
            out_data_reg <= {5'b00000, fin_status_reg, ok_out, fill_out};
        end
    end

    // Checks on the block's own logic.
    `IP6CS_ASSERT_IMP(a_pos_saturates, 1'b1, pos_reg <= POS_W'(MAX_PACKET_BYTES),
        "byte position passed the packet size limit")
    `IP6CS_ASSERT_NXT(a_state_cleared, in_adv && in_last_reg, pos_reg == '0 && sum_reg == '0,
        "packet state not cleared after a final byte")
    `IP6CS_ASSERT_IMP(a_error_zero, m_tvalid && m_tdata[18:17] != ST_OK,
        m_tdata[15:0] == 16'h0000 && !m_tdata[16], "error result carries a checksum")
    `IP6CS_ASSERT_IMP(a_udp_nonzero, fin_v_reg && fin_nh_reg == PROTO_UDP, fill_calc != 16'h0000,
        "UDP fill value of zero")
    `IP6CS_ASSERT_IMP(a_fin_not_lost, fin_v_reg && !out_ready, !(in_adv && in_last_reg),
        "final byte overwrote a waiting sum")

endmodule
